// ===== rtl/shadow_map_depth_test_top_defines.svh =====
// assertion macros used by smdt_back
`ifndef SHADOW_MAP_DEPTH_TEST_TOP_DEFINES_SVH
`define SHADOW_MAP_DEPTH_TEST_TOP_DEFINES_SVH

`ifndef SYNTH
`define SMDT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("smdt check failed");
`define SMDT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("smdt check failed");
`else
`define SMDT_ASSERT(label, prop)
`define SMDT_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/smdt_pkg.sv =====
package smdt_pkg;

  // default sizes
  localparam int MAP_SIZE_DEF   = 1024;
  localparam int DEPTH_BITS_DEF = 16;

  // fixed-point constants
  localparam logic [11:0] BIAS_SLOPE = 12'd3277;
  localparam logic [12:0] BIAS_MIN   = 13'd328;
  localparam logic [16:0] ATT_SHADOW = 17'd13107;
  localparam logic [16:0] ATT_FULL   = 17'd65536;

  // register indexes
  localparam logic [2:0] REG_PROJ_X_LO = 3'd0;
  localparam logic [2:0] REG_PROJ_X_HI = 3'd1;
  localparam logic [2:0] REG_PROJ_Y_LO = 3'd2;
  localparam logic [2:0] REG_PROJ_Y_HI = 3'd3;
  localparam logic [2:0] REG_PROJ_Z_LO = 3'd4;
  localparam logic [2:0] REG_PROJ_Z_HI = 3'd5;
  localparam logic [2:0] REG_LIGHT     = 3'd6;
  localparam logic [2:0] REG_PCF       = 3'd7;

  typedef enum logic [2:0] {
    F_IDLE, F_DOT, F_PROJ, F_MAP, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_READ, B_LAST, B_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  // attenuation from texels compared and texels in shadow
  function automatic logic [16:0] att_lookup(input logic [2:0] total,
                                             input logic [2:0] cnt);
    logic [16:0] a;
    a = ATT_FULL;
    unique case ({total, cnt})
      {3'd1, 3'd1}: a = ATT_SHADOW;
      {3'd2, 3'd1}: a = 17'd32768;
      {3'd2, 3'd2}: a = ATT_SHADOW;
      {3'd3, 3'd1}: a = 17'd43691;
      {3'd3, 3'd2}: a = 17'd21845;
      {3'd3, 3'd3}: a = ATT_SHADOW;
      {3'd4, 3'd1}: a = 17'd49152;
      {3'd4, 3'd2}: a = 17'd32768;
      {3'd4, 3'd3}: a = 17'd16384;
      {3'd4, 3'd4}: a = ATT_SHADOW;
      default:      a = ATT_FULL;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/shadow_map_depth_test_top.sv =====
// Shadow-map depth test. A write transaction (tuser 0) stores one depth texel;
// a query transaction (tuser 1) yields one result. The front end takes a new
// transaction only when idle: three dot-product steps and nine matrix steps go
// one at a time through a single 32x32 multiplier, then a bias and texel
// mapping step and a step to queue the work, which waits while the queue is
// full. The back end pops a query, makes four reads through the single read
// port of the depth memory for up to four texels, waits for the last read
// data and loads the result once the output is free, overlapped with the next
// front-end item through a two-entry queue. The depth memory has no reset and
// no clearing pass; texels must be written before they are looked up.
module shadow_map_depth_test_top #(
  parameter int MAP_SIZE   = smdt_pkg::MAP_SIZE_DEF,
  parameter int DEPTH_BITS = smdt_pkg::DEPTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // texel_x, texel_y, depth_value, normal_x, normal_y, normal_z,
  // world_x, world_y, world_z
  input  logic [183:0] s_tdata,
  // command
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // attenuation, shadow_count
  output logic [23:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  localparam int QW = 23 + DEPTH_BITS + 4 * $clog2(MAP_SIZE);

  logic               q_push, q_pop;
  logic [QW-1:0]      q_data, q_head;
  smdt_pkg::q_flags_t q_flags;

  smdt_front #(
    .MAP_SIZE   (MAP_SIZE),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_flags   (q_flags)
  );

  smdt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .flags     (q_flags)
  );

  smdt_back #(
    .MAP_SIZE   (MAP_SIZE),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_flags  (q_flags),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/smdt_ram.sv =====
module smdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/smdt_queue.sv =====
module smdt_queue #(
  parameter int WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    head,
  output smdt_pkg::q_flags_t  flags
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  // two-entry fifo between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

  assign head        = slot[rptr];
  assign flags.full  = (count == 2'd2);
  assign flags.empty = (count == 2'd0);

endmodule

// ===== rtl/smdt_front.sv =====
module smdt_front #(
  parameter int MAP_SIZE   = smdt_pkg::MAP_SIZE_DEF,
  parameter int DEPTH_BITS = smdt_pkg::DEPTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [183:0]         s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_wdata,
  output logic                 q_push,
  output logic [23+DEPTH_BITS+4*$clog2(MAP_SIZE)-1:0] q_data,
  input  smdt_pkg::q_flags_t   q_flags
);

  localparam int IW = $clog2(MAP_SIZE);
  localparam logic signed [47:0] MAPS = 48'(MAP_SIZE);
  localparam logic signed [63:0] MAP64 = 64'(MAP_SIZE);

  smdt_pkg::front_state_t fstate, fstate_next;

  // configuration registers
  logic [63:0] proj_reg [6];
  logic [47:0] light_reg;
  logic        pcf_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) proj_reg[i] <= '0;
      light_reg <= '0;
      pcf_reg   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smdt_pkg::REG_PROJ_X_LO: proj_reg[0] <= cfg_wdata;
        smdt_pkg::REG_PROJ_X_HI: proj_reg[1] <= cfg_wdata;
        smdt_pkg::REG_PROJ_Y_LO: proj_reg[2] <= cfg_wdata;
        smdt_pkg::REG_PROJ_Y_HI: proj_reg[3] <= cfg_wdata;
        smdt_pkg::REG_PROJ_Z_LO: proj_reg[4] <= cfg_wdata;
        smdt_pkg::REG_PROJ_Z_HI: proj_reg[5] <= cfg_wdata;
        smdt_pkg::REG_LIGHT:     light_reg   <= cfg_wdata[47:0];
        smdt_pkg::REG_PCF:       pcf_reg     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [9:0]         in_tx, in_ty;
  logic [15:0]        in_depth;
  logic [31:0]        tx32, ty32, dv32;
  logic               wr_ok;
  logic               accept;

  assign in_tx    = s_tdata[9:0];
  assign in_ty    = s_tdata[19:10];
  assign in_depth = s_tdata[35:20];
  assign tx32     = {22'd0, in_tx};
  assign ty32     = {22'd0, in_ty};
  assign dv32     = {16'd0, in_depth};
  assign wr_ok    = (tx32 < 32'(MAP_SIZE)) && (ty32 < 32'(MAP_SIZE));
  assign s_tready = (fstate == smdt_pkg::F_IDLE) && !q_flags.full;
  assign accept   = s_tvalid && s_tready;

  // query operands held for the whole computation
  logic signed [15:0] nrm [3];
  logic signed [31:0] wld [3];

  always_ff @(posedge clk) begin
    if (accept && s_tuser) begin
      nrm[0] <= s_tdata[51:36];
      nrm[1] <= s_tdata[67:52];
      nrm[2] <= s_tdata[83:68];
      wld[0] <= s_tdata[115:84];
      wld[1] <= s_tdata[147:116];
      wld[2] <= s_tdata[179:148];
    end
  end

  // step counters for the shared multiplier
  logic [1:0] k_col, k_row;
  logic       last_col;
  assign last_col = (k_col == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_col <= 2'd0;
      k_row <= 2'd0;
    end else if (fstate == smdt_pkg::F_DOT || fstate == smdt_pkg::F_PROJ) begin
      k_col <= last_col ? 2'd0 : k_col + 2'd1;
      if (fstate == smdt_pkg::F_PROJ && last_col) begin
        k_row <= (k_row == 2'd2) ? 2'd0 : k_row + 2'd1;
      end
    end
  end

  // shared 32x32 signed multiplier
  logic signed [31:0] mul_a, mul_b, tcoef;
  logic signed [63:0] mul_p;
  logic [63:0]        lo_w, hi_w;
  logic signed [15:0] light_c;

  always_comb begin
    lo_w = proj_reg[{k_row, 1'b0}];
    hi_w = proj_reg[{k_row, 1'b1}];
    unique case (k_col)
      2'd0:    light_c = $signed(light_reg[15:0]);
      2'd1:    light_c = $signed(light_reg[31:16]);
      default: light_c = $signed(light_reg[47:32]);
    endcase
    tcoef = $signed(hi_w[63:32]);
    if (fstate == smdt_pkg::F_DOT) begin
      mul_a = 32'(nrm[k_col]);
      mul_b = 32'(light_c);
    end else begin
      unique case (k_col)
        2'd0:    mul_a = $signed(lo_w[31:0]);
        2'd1:    mul_a = $signed(lo_w[63:32]);
        default: mul_a = $signed(hi_w[31:0]);
      endcase
      mul_b = wld[k_col];
    end
  end

  assign mul_p = mul_a * mul_b;

  // accumulators: dot in Q7.28, rows in Q34.16
  logic signed [34:0] dot_acc;
  logic signed [49:0] row_acc, row_sum, term;
  logic signed [49:0] prj [3];

  assign term    = 50'(mul_p >>> 16);
  assign row_sum = ((k_col == 2'd0) ? 50'(tcoef) : row_acc) + term;

  always_ff @(posedge clk) begin
    if (fstate == smdt_pkg::F_DOT) begin
      dot_acc <= ((k_col == 2'd0) ? 35'sd0 : dot_acc) + 35'(mul_p);
    end
    if (fstate == smdt_pkg::F_PROJ) begin
      row_acc <= row_sum;
      if (last_col) begin
        prj[k_row] <= row_sum;
      end
    end
  end

  // bias, texel coordinates and compare depth
  logic signed [35:0] om;
  logic [40:0]        bprod;
  logic [12:0]        bias, bsl;
  logic signed [50:0] pxo, pyo;
  logic signed [63:0] um, vm;
  logic signed [47:0] u, v;
  logic signed [50:0] rz;
  logic               facing;

  always_comb begin
    om    = 36'sd268435456 - 36'(dot_acc);
    bprod = 41'(om[28:0]) * 41'(smdt_pkg::BIAS_SLOPE);
    bsl   = bprod[40:28];
    bias  = smdt_pkg::BIAS_MIN;
    if (om > 36'sd0 && bsl > smdt_pkg::BIAS_MIN) begin
      bias = bsl;
    end
    pxo = 51'(prj[0]) + 51'sd65536;
    pyo = 51'sd65536 - 51'(prj[1]);
    um  = 64'(pxo) * MAP64 + 64'sd65536;
    vm  = 64'(pyo) * MAP64 + 64'sd65536;
  end

  always_ff @(posedge clk) begin
    if (fstate == smdt_pkg::F_MAP) begin
      facing <= !dot_acc[34];
      u      <= 48'(um >>> 17);
      v      <= 48'(vm >>> 17);
      rz     <= 51'(prj[2]) + $signed({38'd0, bias});
    end
  end

  // window selection
  logic [IW-1:0] uc, vc, um1, vm1, c0, c1, r0, r1;
  logic          cv0, cv1, rv0, rv1;
  logic [3:0]    mask;

  always_comb begin
    uc  = (u < 48'sd0) ? '0 : ((u >= MAPS) ? IW'(MAP_SIZE - 1) : u[IW-1:0]);
    vc  = (v < 48'sd0) ? '0 : ((v >= MAPS) ? IW'(MAP_SIZE - 1) : v[IW-1:0]);
    um1 = u[IW-1:0] - IW'(1);
    vm1 = v[IW-1:0] - IW'(1);
    cv0 = (u >= 48'sd1) && (u <= MAPS);
    cv1 = (u >= 48'sd0) && (u < MAPS);
    rv0 = (v >= 48'sd1) && (v <= MAPS);
    rv1 = (v >= 48'sd0) && (v < MAPS);
    if (pcf_reg) begin
      c0   = um1;
      c1   = u[IW-1:0];
      r0   = vm1;
      r1   = v[IW-1:0];
      mask = {cv1 & rv1, cv1 & rv0, cv0 & rv1, cv0 & rv0};
    end else begin
      c0   = uc;
      c1   = uc;
      r0   = vc;
      r1   = vc;
      mask = 4'b0001;
    end
    if (!facing) begin
      mask = 4'b0000;
    end
  end

  // queue entry for writes and queries
  always_comb begin
    if (fstate == smdt_pkg::F_IDLE) begin
      q_push = accept && !s_tuser && wr_ok;
      q_data = {1'b1, 4'b0000, 2'b00, 16'd0, dv32[DEPTH_BITS-1:0],
                {IW{1'b0}}, tx32[IW-1:0], {IW{1'b0}}, ty32[IW-1:0]};
    end else begin
      q_push = (fstate == smdt_pkg::F_PUSH) && !q_flags.full;
      q_data = {1'b0, mask, rz[50], (rz >= 51'sd65536), rz[15:0],
                {DEPTH_BITS{1'b0}}, c1, c0, r1, r0};
    end
  end

  // next state
  always_comb begin
    fstate_next = fstate;
    unique case (fstate)
      smdt_pkg::F_IDLE: if (accept && s_tuser) fstate_next = smdt_pkg::F_DOT;
      smdt_pkg::F_DOT:  if (last_col) fstate_next = smdt_pkg::F_PROJ;
      smdt_pkg::F_PROJ: if (last_col && k_row == 2'd2) fstate_next = smdt_pkg::F_MAP;
      smdt_pkg::F_MAP:  fstate_next = smdt_pkg::F_PUSH;
      smdt_pkg::F_PUSH: if (!q_flags.full) fstate_next = smdt_pkg::F_IDLE;
      default:          fstate_next = smdt_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= smdt_pkg::F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

endmodule

// ===== rtl/smdt_back.sv =====
`include "shadow_map_depth_test_top_defines.svh"

module smdt_back #(
  parameter int MAP_SIZE   = smdt_pkg::MAP_SIZE_DEF,
  parameter int DEPTH_BITS = smdt_pkg::DEPTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [23+DEPTH_BITS+4*$clog2(MAP_SIZE)-1:0] q_head,
  input  smdt_pkg::q_flags_t  q_flags,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata
);

  localparam int IW = $clog2(MAP_SIZE);
  localparam int AW = $clog2(MAP_SIZE * MAP_SIZE);

  smdt_pkg::back_state_t bstate, bstate_next;

  // head of queue
  logic                  h_write;
  logic [3:0]            h_mask;
  logic                  h_neg, h_big;
  logic [15:0]           h_rz;
  logic [DEPTH_BITS-1:0] h_wdata;
  logic [IW-1:0]         h_c1, h_c0, h_r1, h_r0;

  assign {h_write, h_mask, h_neg, h_big, h_rz, h_wdata, h_c1, h_c0, h_r1, h_r0} = q_head;

  // latched query
  logic [3:0]    e_mask;
  logic          e_neg, e_big;
  logic [15:0]   e_rz;
  logic [IW-1:0] e_c1, e_c0, e_r1, e_r0;
  logic [1:0]    slot;
  logic          rd_pend;
  logic [1:0]    rd_slot;
  logic [2:0]    cnt;
  logic          load_out;

  always_ff @(posedge clk) begin
    if (q_pop && !h_write) begin
      e_mask <= h_mask;
      e_neg  <= h_neg;
      e_big  <= h_big;
      e_rz   <= h_rz;
      e_c1   <= h_c1;
      e_c0   <= h_c0;
      e_r1   <= h_r1;
      e_r0   <= h_r0;
    end
  end

  // depth store
  logic                  ram_we, ram_re;
  logic [AW-1:0]         waddr, raddr;
  logic [DEPTH_BITS-1:0] rdata;
  logic [IW-1:0]         sel_c, sel_r;

  assign sel_c  = slot[1] ? e_c1 : e_c0;
  assign sel_r  = slot[0] ? e_r1 : e_r0;
  assign waddr  = AW'(h_r0) * AW'(MAP_SIZE) + AW'(h_c0);
  assign raddr  = AW'(sel_r) * AW'(MAP_SIZE) + AW'(sel_c);
  assign ram_we = q_pop && h_write;
  assign ram_re = (bstate == smdt_pkg::B_READ);

  smdt_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (MAP_SIZE * MAP_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (h_wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // depth compare on returning data
  logic shadow;
  assign shadow = e_neg ||
    (!e_big && ({rdata, 16'd0} > {e_rz, {DEPTH_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      slot    <= 2'd0;
    end else begin
      rd_pend <= ram_re;
      slot    <= ram_re ? slot + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= slot;
    if (bstate == smdt_pkg::B_IDLE) begin
      cnt <= 3'd0;
    end else if (rd_pend && e_mask[rd_slot] && shadow) begin
      cnt <= cnt + 3'd1;
    end
  end

  // result register
  logic [2:0]  total;
  logic [16:0] att;
  logic [2:0]  out_cnt;

  assign total    = 3'($countones(e_mask));
  assign load_out = (bstate == smdt_pkg::B_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      att     <= smdt_pkg::att_lookup(total, cnt);
      out_cnt <= cnt;
    end
  end

  assign m_tdata = {4'd0, out_cnt, att};

  // queue pop
  always_comb begin
    q_pop = (bstate == smdt_pkg::B_IDLE) && !q_flags.empty;
  end

  // next state
  always_comb begin
    bstate_next = bstate;
    unique case (bstate)
      smdt_pkg::B_IDLE: if (q_pop && !h_write) bstate_next = smdt_pkg::B_READ;
      smdt_pkg::B_READ: if (slot == 2'd3) bstate_next = smdt_pkg::B_LAST;
      smdt_pkg::B_LAST: bstate_next = smdt_pkg::B_DONE;
      smdt_pkg::B_DONE: if (load_out) bstate_next = smdt_pkg::B_IDLE;
      default:          bstate_next = smdt_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= smdt_pkg::B_IDLE;
    end else begin
      bstate <= bstate_next;
    end
  end

  // checks
  `SMDT_ASSERT(a_last_has_read, (bstate == smdt_pkg::B_LAST) |-> rd_pend)
  `SMDT_ASSERT(a_cnt_bounded, (bstate == smdt_pkg::B_DONE) |-> (cnt <= total))
  `SMDT_ASSERT(a_load_after_last,
    (load_out && $past(bstate) == smdt_pkg::B_LAST) |-> !rd_pend)
  `SMDT_ASSERT_ALWAYS(a_pop_nonempty, q_pop |-> !q_flags.empty)

endmodule
